FILE: rtl/ata_pio_request_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ata_pio_request_sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_REQUEST_SEQUENCER_DEFINES_SVH
`define ATA_PIO_REQUEST_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define APR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("apr port check failed");

// next-cycle implication, checked outside reset
`define APR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("apr port check failed");

`endif

FILE: rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// types and constants of the ata pio request sequencer
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // result kinds
    localparam logic [2:0] OK_REGW = 3'd0;
    localparam logic [2:0] OK_DOUT = 3'd1;
    localparam logic [2:0] OK_DIN  = 3'd2;
    localparam logic [2:0] OK_DONE = 3'd3;
    localparam logic [2:0] OK_REJ  = 3'd4;

    // task file ports
    localparam logic [9:0] PORT_CTL   = 10'h3f6;
    localparam logic [9:0] PORT_CNT   = 10'h1f2;
    localparam logic [9:0] PORT_LBA0  = 10'h1f3;
    localparam logic [9:0] PORT_LBA1  = 10'h1f4;
    localparam logic [9:0] PORT_LBA2  = 10'h1f5;
    localparam logic [9:0] PORT_DEV   = 10'h1f6;
    localparam logic [9:0] PORT_CMD   = 10'h1f7;

    localparam logic [7:0] OPC_WR_SECTORS = 8'h30;
    localparam logic [7:0] OPC_RD_SECTORS = 8'h20;
    localparam logic [2:0] DEV_LBA    = 3'b111;
    localparam logic [7:0] ST_FAIL    = 8'h21;

    typedef struct packed {
        logic [7:0]  tag;
        logic [27:0] sector;
        logic        drive;
        logic        is_write;
    } t_entry;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [9:0] port;
        logic [7:0] value;
        logic [7:0] done_tag;
        logic       last;
    } t_res;

endpackage

FILE: rtl/apr_if.sv
// ----------------------------------------------------------------------------
// apr_if
// request/interrupt channel and result channel
// ----------------------------------------------------------------------------
interface apr_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tag;
    logic [27:0] sector;
    logic        drive;
    logic        is_write;
    logic [7:0]  status;

    modport source (output valid, kind, tag, sector, drive, is_write, status, input ready);
    modport sink   (input valid, kind, tag, sector, drive, is_write, status, output ready);
endinterface

interface apr_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [9:0] port;
    logic [7:0] value;
    logic [7:0] done_tag;
    logic       last;

    modport source (output valid, out_kind, port, value, done_tag, last, input ready);
    modport sink   (input valid, out_kind, port, value, done_tag, last, output ready);
endinterface

FILE: rtl/ata_pio_request_sequencer.sv
// ----------------------------------------------------------------------------
// ata_pio_request_sequencer
// lba28 pio request queue, emits task file writes and completions
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    kind tag sector drive is_write status
//  o_res     out  valid/ready    out_kind port value done_tag last
//  i_cfg     in   write enable   second_drive_present
//
//  one item in flight: a request gives up to 8 results, an interrupt up to
//  10 and first passes a load state for the ram read of the head entry.
//  results leave one per cycle through an output register, stalls on o_res
//  hold the sequencer. reset is synchronous and needs no clearing pass: only
//  live queue entries are ever read.
// ----------------------------------------------------------------------------
module ata_pio_request_sequencer #(
    parameter int QUEUE_DEPTH = apr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    apr_req_if.sink         i_req,
    apr_res_if.source       o_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = $bits(apr_pkg::t_entry);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        SP_REJ, SP_DIN, SP_DONE, SP_CTL, SP_CNT, SP_LBA0,
        SP_LBA1, SP_LBA2, SP_DEV, SP_CMD, SP_DOUT
    } t_step;

    t_state              r_state, n_state;
    t_step               r_step, n_step;
    apr_pkg::t_entry     r_ent, n_ent;
    logic                r_st_ok, n_st_ok;
    logic                r_more, n_more;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_sdp;
    logic                r_ovalid, n_ovalid;
    apr_pkg::t_res       r_out, n_out;

    apr_pkg::t_entry     w_in;
    apr_pkg::t_entry     w_rd;
    apr_pkg::t_res       w_res;
    logic [ENT_W-1:0]    w_rdata;
    logic                w_acc, w_slot, w_rej, w_we, w_emit;
    logic [PTR_W-1:0]    w_head_nx, w_tail_nx;

    // ram reads the head every cycle; writes only happen while idle, so the
    // head data is settled by the time it is used
    apr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_in),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_rd   = apr_pkg::t_entry'(w_rdata);
    assign w_in   = '{tag: i_req.tag, sector: i_req.sector,
                      drive: i_req.drive, is_write: i_req.is_write};

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc  = i_req.valid && i_req.ready;
    assign w_slot = !r_ovalid || o_res.ready;
    assign w_rej  = (i_req.drive && !r_sdp) || (r_count == CNT_W'(QUEUE_DEPTH));

    assign w_head_nx = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_ent   = r_ent;
        n_st_ok = r_st_ok;
        n_more  = r_more;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        w_we    = 1'b0;
        w_emit  = 1'b0;
        w_res   = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (!i_req.kind) begin
                        if (w_rej) begin
                            n_ent   = w_in;
                            n_step  = SP_REJ;
                            n_state = ST_EMIT;
                        end else begin
                            w_we    = 1'b1;
                            n_tail  = w_tail_nx;
                            n_count = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_ent   = w_in;
                                n_step  = SP_CTL;
                                n_state = ST_EMIT;
                            end
                        end
                    end else if (r_count != '0) begin
                        n_head  = w_head_nx;
                        n_count = r_count - 1'b1;
                        n_st_ok = (i_req.status & apr_pkg::ST_FAIL) == '0;
                        n_more  = (r_count != CNT_W'(1));
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_ent   = w_rd;
                n_step  = (!w_rd.is_write && r_st_ok) ? SP_DIN : SP_DONE;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    case (r_step)
                        SP_REJ: begin
                            w_res.out_kind = apr_pkg::OK_REJ;
                            w_res.done_tag = r_ent.tag;
                            w_res.last     = 1'b1;
                            n_state        = ST_IDLE;
                        end
                        SP_DIN: begin
                            w_res.out_kind = apr_pkg::OK_DIN;
                            w_res.done_tag = r_ent.tag;
                            n_step         = SP_DONE;
                        end
                        SP_DONE: begin
                            w_res.out_kind = apr_pkg::OK_DONE;
                            w_res.done_tag = r_ent.tag;
                            w_res.last     = !r_more;
                            // ram already holds the new head at this point
                            if (r_more) begin
                                n_ent  = w_rd;
                                n_step = SP_CTL;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        SP_CTL: begin
                            w_res.port = apr_pkg::PORT_CTL;
                            n_step     = SP_CNT;
                        end
                        SP_CNT: begin
                            w_res.port  = apr_pkg::PORT_CNT;
                            w_res.value = 8'd1;
                            n_step      = SP_LBA0;
                        end
                        SP_LBA0: begin
                            w_res.port  = apr_pkg::PORT_LBA0;
                            w_res.value = r_ent.sector[7:0];
                            n_step      = SP_LBA1;
                        end
                        SP_LBA1: begin
                            w_res.port  = apr_pkg::PORT_LBA1;
                            w_res.value = r_ent.sector[15:8];
                            n_step      = SP_LBA2;
                        end
                        SP_LBA2: begin
                            w_res.port  = apr_pkg::PORT_LBA2;
                            w_res.value = r_ent.sector[23:16];
                            n_step      = SP_DEV;
                        end
                        SP_DEV: begin
                            w_res.port  = apr_pkg::PORT_DEV;
                            w_res.value = {apr_pkg::DEV_LBA, r_ent.drive,
                                           r_ent.sector[27:24]};
                            n_step      = SP_CMD;
                        end
                        SP_CMD: begin
                            w_res.port  = apr_pkg::PORT_CMD;
                            w_res.value = r_ent.is_write ? apr_pkg::OPC_WR_SECTORS
                                                         : apr_pkg::OPC_RD_SECTORS;
                            w_res.last  = !r_ent.is_write;
                            if (r_ent.is_write) begin
                                n_step = SP_DOUT;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        SP_DOUT: begin
                            w_res.out_kind = apr_pkg::OK_DOUT;
                            w_res.done_tag = r_ent.tag;
                            w_res.last     = 1'b1;
                            n_state        = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_ovalid = w_emit ? 1'b1 : (o_res.ready ? 1'b0 : r_ovalid);
        n_out    = w_emit ? w_res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_REJ;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_sdp    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_sdp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_st_ok <= n_st_ok;
        r_more  <= n_more;
        r_out   <= n_out;
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.out_kind = r_out.out_kind;
    assign o_res.port     = r_out.port;
    assign o_res.value    = r_out.value;
    assign o_res.done_tag = r_out.done_tag;
    assign o_res.last     = r_out.last;

endmodule

FILE: rtl/apr_ram.sv
// ----------------------------------------------------------------------------
// apr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module apr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/apr_checker.sv
// ----------------------------------------------------------------------------
// apr_checker
// port level checks of the ata pio request sequencer
// ----------------------------------------------------------------------------
`include "ata_pio_request_sequencer_defines.svh"

module apr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [2:0] i_res_kind,
    input logic [9:0] i_res_port,
    input logic [7:0] i_res_value,
    input logic [7:0] i_res_tag,
    input logic       i_res_last
);

    // a stalled result holds
    `APR_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_kind) && $stable(i_res_tag) && $stable(i_res_port))

    // rejections and data-out markers always close an item's results
    `APR_ASSERT_IMPLY(a_close_last,
        i_res_valid && (i_res_kind == apr_pkg::OK_REJ || i_res_kind == apr_pkg::OK_DOUT),
        i_res_last)

    // only register writes carry a port and value, and they carry no tag
    `APR_ASSERT_IMPLY(a_regw_fields,
        i_res_valid && i_res_kind != apr_pkg::OK_REGW,
        i_res_port == '0 && i_res_value == '0)

    `APR_ASSERT_IMPLY(a_regw_tag,
        i_res_valid && i_res_kind == apr_pkg::OK_REGW, i_res_tag == '0)

    // a data-in marker never closes an item's results, its completion follows
    `APR_ASSERT_IMPLY(a_din_not_last,
        i_res_valid && i_res_kind == apr_pkg::OK_DIN, !i_res_last)

endmodule

bind ata_pio_request_sequencer apr_checker u_apr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.out_kind),
    .i_res_port  (o_res.port),
    .i_res_value (o_res.value),
    .i_res_tag   (o_res.done_tag),
    .i_res_last  (o_res.last)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ata pio request sequencer: requests and
// interrupts go in under random idling, every task file write, data marker,
// completion and rejection coming out is checked against a queue model
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic       KIND_REQ       = 1'b0;
    localparam logic       KIND_IRQ       = 1'b1;
    localparam logic [7:0] CTL_CLEAR      = 8'h00;
    localparam logic [7:0] ONE_SECTOR     = 8'h01;
    localparam logic [7:0] ST_DF_BIT      = 8'h20;
    localparam logic [7:0] ST_ERR_BIT     = 8'h01;
    localparam int         QDEPTH         = apr_pkg::QUEUE_DEPTH_DEF;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         ITEMS_PER_PHASE = 65;

    // ------------------------------------------------------------------------
    // queue model and result checker
    // ------------------------------------------------------------------------
    class taskfile_scoreboard;
        apr_pkg::t_entry queued_reqs[$];
        apr_pkg::t_res   expected_results[$];
        bit     drive1_present;
        int     errors;

        function void set_drive1(bit v);
            drive1_present = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int queued();
            return queued_reqs.size();
        endfunction

        function void push_res(logic [2:0] k, logic [9:0] p, logic [7:0] v,
                               logic [7:0] t);
            apr_pkg::t_res r;
            r.out_kind = k;
            r.port     = p;
            r.value    = v;
            r.done_tag = t;
            r.last     = 1'b0;
            expected_results.push_back(r);
        endfunction

        // command sequence for the entry now at the head of the queue
        function void issue_taskfile(apr_pkg::t_entry e);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_CTL, CTL_CLEAR, 8'h00);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_CNT, ONE_SECTOR, 8'h00);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_LBA0, e.sector[7:0], 8'h00);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_LBA1, e.sector[15:8], 8'h00);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_LBA2, e.sector[23:16], 8'h00);
            push_res(apr_pkg::OK_REGW, apr_pkg::PORT_DEV,
                     {apr_pkg::DEV_LBA, e.drive, e.sector[27:24]}, 8'h00);
            if (e.is_write) begin
                push_res(apr_pkg::OK_REGW, apr_pkg::PORT_CMD, apr_pkg::OPC_WR_SECTORS,
                         8'h00);
                push_res(apr_pkg::OK_DOUT, 10'h000, 8'h00, e.tag);
            end else begin
                push_res(apr_pkg::OK_REGW, apr_pkg::PORT_CMD, apr_pkg::OPC_RD_SECTORS,
                         8'h00);
            end
        endfunction

        function void note_item(logic kind, apr_pkg::t_entry e, logic [7:0] st);
            int              prior_size;
            apr_pkg::t_entry head;
            prior_size = expected_results.size();
            if (kind == KIND_REQ) begin
                if ((e.drive && !drive1_present) || queued_reqs.size() >= QDEPTH) begin
                    push_res(apr_pkg::OK_REJ, 10'h000, 8'h00, e.tag);
                end else begin
                    queued_reqs.push_back(e);
                    if (queued_reqs.size() == 1)
                        issue_taskfile(e);
                end
            end else if (queued_reqs.size() != 0) begin
                head = queued_reqs.pop_front();
                if (!head.is_write && (st & apr_pkg::ST_FAIL) == 8'h00)
                    push_res(apr_pkg::OK_DIN, 10'h000, 8'h00, head.tag);
                push_res(apr_pkg::OK_DONE, 10'h000, 8'h00, head.tag);
                if (queued_reqs.size() != 0)
                    issue_taskfile(queued_reqs[0]);
            end
            if (expected_results.size() > prior_size)
                expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch: %s", msg);
        endtask

        task check_result(apr_pkg::t_res got);
            apr_pkg::t_res want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d port %03h value %02h tag %02h",
                                 got.out_kind, got.port, got.value, got.done_tag));
                return;
            end
            want = expected_results.pop_front();
            if (got.out_kind !== want.out_kind || got.port !== want.port ||
                got.value !== want.value || got.done_tag !== want.done_tag ||
                got.last !== want.last) begin
                report($sformatf("got k%0d p%03h v%02h t%02h l%0d, want k%0d p%03h v%02h t%02h l%0d",
                                 got.out_kind, got.port, got.value, got.done_tag, got.last,
                                 want.out_kind, want.port, want.value, want.done_tag,
                                 want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    apr_req_if req_if ();
    apr_res_if res_if ();

    ata_pio_request_sequencer #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    taskfile_scoreboard sb = new();

    int source_idle_pct;
    int sink_stall_pct;
    bit hold_req;
    int hold_left;
    int useful_items;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result sink, with the long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        apr_pkg::t_entry e;
        apr_pkg::t_res   r;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                e.tag      = req_if.tag;
                e.sector   = req_if.sector;
                e.drive    = req_if.drive;
                e.is_write = req_if.is_write;
                sb.note_item(req_if.kind, e, req_if.status);
            end
            if (res_if.valid && res_if.ready) begin
                r.out_kind = res_if.out_kind;
                r.port     = res_if.port;
                r.value    = res_if.value;
                r.done_tag = res_if.done_tag;
                r.last     = res_if.last;
                sb.check_result(r);
            end
        end
    end

    // no item moving on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ata_pio_request_sequencer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input apr_pkg::t_entry e,
                             input logic [7:0] st);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < source_idle_pct)
            gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // interrupts on an empty queue are dropped by the block
        if (!(kind == KIND_IRQ && sb.queued() == 0))
            useful_items++;
        req_if.valid    <= 1'b1;
        req_if.kind     <= kind;
        req_if.tag      <= e.tag;
        req_if.sector   <= e.sector;
        req_if.drive    <= e.drive;
        req_if.is_write <= e.is_write;
        req_if.status   <= st;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_req(input logic [7:0] tag, input logic [27:0] sector,
                            input logic drive, input logic is_write);
        apr_pkg::t_entry e;
        e.tag      = tag;
        e.sector   = sector;
        e.drive    = drive;
        e.is_write = is_write;
        send_item(KIND_REQ, e, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_irq(input logic [7:0] st);
        logic [31:0]     r;
        apr_pkg::t_entry e;
        r          = $urandom();
        e.tag      = r[7:0];
        e.sector   = r[31:4];
        e.drive    = r[1];
        e.is_write = r[2];
        send_item(KIND_IRQ, e, st);
    endtask

    task automatic send_random_req();
        logic [31:0] r;
        logic [31:0] s;
        r = $urandom();
        s = $urandom();
        send_req(r[7:0], s[27:0], r[8], r[9]);
    endtask

    task automatic send_random_irq();
        logic [7:0] st;
        st = 8'($urandom_range(0, 255));
        // at least half of the reads should succeed
        if ($urandom_range(0, 1) == 0)
            st = st & ~apr_pkg::ST_FAIL;
        send_irq(st);
    endtask

    // write the register only with the block idle
    task automatic write_drive1(input bit v);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        sb.set_drive1(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // bursts of requests, then interrupts to retire them; now and then a stray item
    task automatic run_traffic(input int n_items);
        int goal;
        int burst;
        int irqs;
        int i;
        goal = useful_items + n_items;
        while (useful_items < goal) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 7) == 0)
                    burst = $urandom_range(QDEPTH - 2, QDEPTH + 4);
                else
                    burst = $urandom_range(1, 4);
                for (i = 0; i < burst; i++)
                    send_random_req();
                irqs = burst + $urandom_range(0, 2) - 1;
                for (i = 0; i < irqs; i++)
                    send_random_irq();
            end else if ($urandom_range(0, 1) == 0) begin
                send_random_req();
            end else begin
                send_random_irq();
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        req_if.valid    = 1'b0;
        req_if.kind     = KIND_REQ;
        req_if.tag      = 8'h00;
        req_if.sector   = 28'h0000000;
        req_if.drive    = 1'b0;
        req_if.is_write = 1'b0;
        req_if.status   = 8'h00;
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_req        = 1'b0;
        useful_items    = 0;
        quiet_cycles    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_drive1(1'b0);
        send_req(8'hff, 28'h0000000, 1'b1, 1'b1);   // slave absent
        send_irq(8'hff);                            // nothing queued
        send_req(8'h00, 28'h0000000, 1'b0, 1'b0);
        send_req(8'hff, 28'hfffffff, 1'b0, 1'b1);   // waits behind the read
        send_req(8'h5a, 28'h5a5a5a5, 1'b0, 1'b0);
        send_irq(8'h00);
        send_irq(apr_pkg::ST_FAIL);
        send_irq(ST_DF_BIT);                        // read fails on df
        send_req(8'h3c, 28'ha5a5a5a, 1'b0, 1'b0);
        send_irq(ST_ERR_BIT);                       // read fails on err
        send_req(8'h81, 28'h1234567, 1'b0, 1'b0);
        send_irq(8'hde);
        write_drive1(1'b1);
        send_req(8'h01, 28'hfffffff, 1'b1, 1'b1);
        send_req(8'h02, 28'h0000000, 1'b1, 1'b0);
        send_irq(8'h80);
        send_irq(8'h40);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    source_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    source_idle_pct = 51;
                    sink_stall_pct  = 0;
                end
                2: begin
                    source_idle_pct = 0;
                    sink_stall_pct  = 51;
                end
                default: begin
                    source_idle_pct = 25;
                    sink_stall_pct  = 25;
                end
            endcase
            write_drive1(phase % 2 == 1);
            // sink stops while requests keep coming, so the block backs up
            if (phase == 0)
                hold_req = 1'b1;
            run_traffic(ITEMS_PER_PHASE);
        end

        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report("results still expected at the end");
        if (sb.errors == 0) begin
            $display("PASS ata_pio_request_sequencer");
        end else begin
            $display("FAIL ata_pio_request_sequencer");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/apr_ram.sv
rtl/ata_pio_request_sequencer.sv
rtl/apr_checker.sv
tb/sv/tb_top.sv
